// ===== sv/tx_alc_guard_assert.svh =====
// assertion macros for the transmit guard
`ifndef TX_ALC_GUARD_ASSERT_SVH
`define TX_ALC_GUARD_ASSERT_SVH
`define TAG_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("%m: lbl");
`define TAG_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("%m: lbl");
`endif

// ===== sv/tag_pkg.sv =====
`timescale 1ns / 1ps
package tag_pkg;
    localparam int TIME_BITS = 32;
    localparam int IN_BITS = 96;
    localparam int OUT_BITS = 32;
    localparam logic [16:0] GAIN_UP_Q16 = 17'd92682;
    localparam logic [16:0] GAIN_DOWN_Q16 = 17'd46341;

    typedef enum logic [2:0] {
        ACT_BEGIN = 3'd0,
        ACT_ACK   = 3'd1,
        ACT_AUDIO = 3'd2,
        ACT_TICK  = 3'd3,
        ACT_METER = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_TRIP  = 2'd1,
        OUT_RED   = 2'd2,
        OUT_CALIB = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        TRIP_NONE      = 4'd0,
        TRIP_FAULT     = 4'd1,
        TRIP_CANCEL    = 4'd2,
        TRIP_METER_TO  = 4'd3,
        TRIP_ALC_PERS  = 4'd4,
        TRIP_CAL_TO    = 4'd5,
        TRIP_NO_AUDIO  = 4'd6,
        TRIP_BAD_METER = 4'd7,
        TRIP_RF        = 4'd8,
        TRIP_COMP      = 4'd9,
        TRIP_ALC_EXC   = 4'd10,
        TRIP_CAL_GAIN  = 4'd11,
        TRIP_ALC_MIN   = 4'd12
    } trip_t;

    typedef enum logic [2:0] {
        REG_MIN_GAIN  = 3'd0,
        REG_CAL_GAIN  = 3'd1,
        REG_MAX_GAIN  = 3'd2,
        REG_REDUCE    = 3'd3,
        REG_STOP      = 3'd4,
        REG_METER_TO  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]           action;
        logic [TIME_BITS-1:0] now;
        logic                 sid_nz;
        logic                 calibrate;
        logic                 fault;
        logic                 cancel;
        logic                 meter_ok;
        logic [9:0]           alc;
        logic                 comp_nz;
        logic                 rf_nz;
    } event_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] outcome;
        logic [3:0] trip_code;
        logic [15:0] gain;
        logic       running;
        logic       latched;
        logic       calib;
        logic       close_s;
    } result_t;

    // now >= t && now - t >= k
    function automatic logic age_ge(input logic [TIME_BITS-1:0] now,
                                    input logic [TIME_BITS-1:0] t,
                                    input logic [TIME_BITS-1:0] k);
        logic [TIME_BITS-1:0] d;
        d = now - t;
        return (now >= t) && (d >= k);
    endfunction
endpackage

// ===== sv/tag_front.sv =====
`timescale 1ns / 1ps
module tag_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tag_pkg::IN_BITS-1:0] s_tdata,
    output logic                        q_valid,
    input  logic                        q_ready,
    output tag_pkg::event_t             q_event
);
    // two entry queue
    tag_pkg::event_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    tag_pkg::event_t ev;
    logic            push, pop;

    always_comb begin
        ev.action    = s_tdata[2:0];
        ev.now       = s_tdata[34:3];
        ev.sid_nz    = |s_tdata[50:35];
        ev.calibrate = s_tdata[51];
        ev.fault     = s_tdata[52];
        ev.cancel    = s_tdata[53];
        ev.meter_ok  = s_tdata[54];
        ev.alc       = s_tdata[64:55];
        ev.comp_nz   = |s_tdata[74:65];
        ev.rf_nz     = |s_tdata[84:75];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_event  = mem_reg[rd_ptr_reg];
    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= ev;
        end
    end

    `include "tx_alc_guard_assert.svh"
    `TAG_ASSERT_IMP(a_no_overflow, aclk, aresetn, cnt_reg == 2'd2, !push)
    `TAG_ASSERT_NEXT(a_cnt_track, aclk, aresetn, push && !pop && cnt_reg == 2'd0, cnt_reg == 2'd1)
    `TAG_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3)
endmodule

// ===== sv/tag_back.sv =====
`timescale 1ns / 1ps
module tag_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_valid,
    output logic                q_ready,
    input  tag_pkg::event_t     q_event,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [tag_pkg::OUT_BITS-1:0] m_tdata
);
    localparam int TB = tag_pkg::TIME_BITS;
    localparam int ST_STABLE = 0, ST_FIRST = 1, ST_LAST = 2, ST_HSINCE = 3,
        ST_RED = 4, ST_LHIGH = 5;

    logic [15:0] min_gain_reg, cal_gain_reg, max_gain_reg, tmo_reg;
    logic [9:0]  reduce_reg, stop_reg;

    logic        act_reg, act_next, latch_reg, latch_next, cal_reg, cal_next;
    logic [15:0] gain_reg, gain_next;
    logic [TB-1:0] start_reg, start_next, adj_reg, adj_next, mtime_reg, mtime_next;
    logic [TB-1:0] sv_reg [6];
    logic [TB-1:0] sv_next [6];
    logic [5:0]  sok_reg, sok_next;
    logic [3:0]  hc_reg, hc_next;
    logic        ov_reg;
    tag_pkg::result_t res_reg, res;

    // products computed ahead from the current gain
    logic [32:0] up_prod, dn_prod;
    logic [16:0] up_g, dn_g;
    assign up_prod = gain_reg * tag_pkg::GAIN_UP_Q16;
    assign dn_prod = gain_reg * tag_pkg::GAIN_DOWN_Q16;
    assign up_g = up_prod[32:16];
    assign dn_g = dn_prod[32:16];

    logic take;
    assign q_ready = !ov_reg || m_tready;
    assign take = q_valid && q_ready;

    always_comb begin
        logic [TB-1:0] now, ref_t, g0;
        logic first_ok, done, tick_trip, trip;
        logic [3:0] code;
        logic [1:0] oc;
        logic [15:0] g;
        now = q_event.now;
        act_next = act_reg; latch_next = latch_reg; cal_next = cal_reg;
        gain_next = gain_reg; start_next = start_reg; adj_next = adj_reg;
        mtime_next = mtime_reg; sok_next = sok_reg; hc_next = hc_reg;
        for (int i = 0; i < 6; i++) sv_next[i] = sv_reg[i];
        res = '0;
        trip = 1'b0; code = tag_pkg::TRIP_NONE; oc = tag_pkg::OUT_NONE;
        done = 1'b0; tick_trip = 1'b0; g = 16'd0; g0 = '0;
        first_ok = sok_reg[ST_FIRST];
        ref_t = sok_reg[ST_LAST] ? sv_reg[ST_LAST] : start_reg;
        if (act_reg) begin
            if (q_event.fault) begin tick_trip = 1'b1; code = tag_pkg::TRIP_FAULT; end
            else if (q_event.cancel) begin tick_trip = 1'b1; code = tag_pkg::TRIP_CANCEL; end
            else if (!tag_pkg::age_ge(now, mtime_reg, {{(TB-16){1'b0}}, tmo_reg}) == 1'b0
                     || now < mtime_reg) begin
                tick_trip = 1'b1; code = tag_pkg::TRIP_METER_TO;
            end else if (hc_reg >= 4'd3 && sok_reg[ST_HSINCE] &&
                         tag_pkg::age_ge(now, sv_reg[ST_HSINCE], TB'(1500))) begin
                tick_trip = 1'b1; code = tag_pkg::TRIP_ALC_PERS;
            end else if (cal_reg && tag_pkg::age_ge(now, start_reg, TB'(15000))) begin
                tick_trip = 1'b1; code = tag_pkg::TRIP_CAL_TO;
            end else if (tag_pkg::age_ge(now, ref_t, TB'(1500))) begin
                tick_trip = 1'b1; code = tag_pkg::TRIP_NO_AUDIO;
            end
        end
        unique case (q_event.action)
            tag_pkg::ACT_BEGIN: begin
                if (!act_reg && !latch_reg && q_event.sid_nz) begin
                    res.accepted = 1'b1;
                    act_next = 1'b1; cal_next = q_event.calibrate;
                    start_next = now; adj_next = now; mtime_next = now;
                    sok_next = '0; hc_next = '0;
                    for (int i = 0; i < 6; i++) sv_next[i] = '0;
                    if (q_event.calibrate) gain_next = cal_gain_reg;
                    else begin
                        g = (gain_reg < max_gain_reg) ? gain_reg : max_gain_reg;
                        gain_next = (g > min_gain_reg) ? g : min_gain_reg;
                    end
                end
            end
            tag_pkg::ACT_ACK: if (!act_reg) latch_next = 1'b0;
            tag_pkg::ACT_AUDIO: begin
                if (act_reg) begin
                    if (!sok_reg[ST_FIRST]) begin
                        sok_next[ST_FIRST] = 1'b1; sv_next[ST_FIRST] = now; adj_next = now;
                    end
                    sok_next[ST_LAST] = 1'b1; sv_next[ST_LAST] = now;
                end
            end
            tag_pkg::ACT_TICK: trip = tick_trip;
            tag_pkg::ACT_METER: begin
                if (act_reg) begin
                    if (!q_event.meter_ok) begin
                        trip = 1'b1; code = tag_pkg::TRIP_BAD_METER;
                    end else if (tick_trip) begin
                        trip = 1'b1;
                    end else begin
                        mtime_next = now;
                        if (cal_reg && q_event.rf_nz) begin
                            trip = 1'b1; code = tag_pkg::TRIP_RF;
                        end else if (q_event.comp_nz) begin
                            trip = 1'b1; code = tag_pkg::TRIP_COMP;
                        end else if (q_event.alc >= stop_reg) begin
                            trip = 1'b1; code = tag_pkg::TRIP_ALC_EXC;
                        end else if (cal_reg && (!first_ok ||
                                !tag_pkg::age_ge(now, sv_reg[ST_FIRST], TB'(600)) ||
                                !tag_pkg::age_ge(now, adj_reg, TB'(600)))) begin
                            sok_next[ST_HSINCE] = 1'b0; sok_next[ST_LHIGH] = 1'b0;
                            hc_next = '0; sok_next[ST_STABLE] = 1'b0;
                        end else if (q_event.alc < reduce_reg) begin
                            sok_next[ST_HSINCE] = 1'b0; sok_next[ST_LHIGH] = 1'b0;
                            hc_next = '0;
                            if (cal_reg) begin
                                if (!sok_reg[ST_LAST] || (now > sv_reg[ST_LAST] &&
                                        (now - sv_reg[ST_LAST]) > TB'(500))) begin
                                    sok_next[ST_STABLE] = 1'b0;
                                end else if (q_event.alc >= 10'd3) begin
                                    g0 = sok_reg[ST_STABLE] ? sv_reg[ST_STABLE] : now;
                                    if (!sok_reg[ST_STABLE]) begin
                                        sok_next[ST_STABLE] = 1'b1; sv_next[ST_STABLE] = now;
                                    end
                                    if (tag_pkg::age_ge(now, g0, TB'(1200)))
                                        oc = tag_pkg::OUT_CALIB;
                                end else begin
                                    sok_next[ST_STABLE] = 1'b0;
                                    if (gain_reg >= max_gain_reg) begin
                                        trip = 1'b1; code = tag_pkg::TRIP_CAL_GAIN;
                                    end else begin
                                        gain_next = (up_g < {1'b0, max_gain_reg}) ?
                                            up_g[15:0] : max_gain_reg;
                                        adj_next = now;
                                    end
                                end
                            end
                        end else begin
                            sok_next[ST_STABLE] = 1'b0;
                            g0 = sok_reg[ST_HSINCE] ? sv_reg[ST_HSINCE] : now;
                            if (!sok_reg[ST_HSINCE]) begin
                                sok_next[ST_HSINCE] = 1'b1; sv_next[ST_HSINCE] = now;
                            end
                            hc_next = hc_reg;
                            if (!sok_reg[ST_LHIGH] ||
                                    tag_pkg::age_ge(now, sv_reg[ST_LHIGH], TB'(200))) begin
                                if (hc_reg < 4'd15) hc_next = hc_reg + 4'd1;
                                sok_next[ST_LHIGH] = 1'b1; sv_next[ST_LHIGH] = now;
                            end
                            if (sok_reg[ST_RED] &&
                                    !tag_pkg::age_ge(now, sv_reg[ST_RED], TB'(400))) begin
                                done = 1'b1;
                            end else if (gain_reg <= min_gain_reg) begin
                                if (hc_next >= 4'd3 && tag_pkg::age_ge(now, g0, TB'(600))) begin
                                    trip = 1'b1; code = tag_pkg::TRIP_ALC_MIN;
                                end
                            end else begin
                                gain_next = (dn_g > {1'b0, min_gain_reg}) ?
                                    dn_g[15:0] : min_gain_reg;
                                adj_next = now;
                                sok_next[ST_RED] = 1'b1; sv_next[ST_RED] = now;
                                oc = tag_pkg::OUT_RED;
                                if (cal_reg) begin
                                    sok_next[ST_HSINCE] = 1'b0; sok_next[ST_LHIGH] = 1'b0;
                                    hc_next = '0;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (trip) begin
            act_next = 1'b0; cal_next = 1'b0; latch_next = 1'b1;
            oc = tag_pkg::OUT_TRIP;
            res.trip_code = code; res.close_s = 1'b1;
            gain_next = gain_reg; adj_next = adj_reg; sok_next = sok_reg; hc_next = hc_reg;
            for (int i = 0; i < 6; i++) sv_next[i] = sv_reg[i];
            if (q_event.action == tag_pkg::ACT_METER && q_event.meter_ok && !tick_trip)
                mtime_next = now;
            else mtime_next = mtime_reg;
        end
        res.outcome = oc; res.gain = gain_next; res.running = act_next;
        res.latched = latch_next; res.calib = cal_next;
        if (done) res.outcome = tag_pkg::OUT_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gain_reg <= 16'd16; cal_gain_reg <= 16'd1024; max_gain_reg <= 16'd32768;
            reduce_reg <= 10'd5; stop_reg <= 10'd10; tmo_reg <= 16'd1000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tag_pkg::REG_MIN_GAIN: min_gain_reg <= cfg_wdata;
                tag_pkg::REG_CAL_GAIN: cal_gain_reg <= cfg_wdata;
                tag_pkg::REG_MAX_GAIN: max_gain_reg <= cfg_wdata;
                tag_pkg::REG_REDUCE:   reduce_reg <= cfg_wdata[9:0];
                tag_pkg::REG_STOP:     stop_reg <= cfg_wdata[9:0];
                tag_pkg::REG_METER_TO: tmo_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0; latch_reg <= 1'b0; cal_reg <= 1'b0; gain_reg <= '0;
            start_reg <= '0; adj_reg <= '0; mtime_reg <= '0; sok_reg <= '0;
            hc_reg <= '0; ov_reg <= 1'b0;
        end else begin
            if (take) begin
                act_reg <= act_next; latch_reg <= latch_next; cal_reg <= cal_next;
                gain_reg <= gain_next; start_reg <= start_next; adj_reg <= adj_next;
                mtime_reg <= mtime_next; sok_reg <= sok_next; hc_reg <= hc_next;
            end
            if (take) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
            for (int i = 0; i < 6; i++) sv_reg[i] <= sv_next[i];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = {5'd0, res_reg.close_s, res_reg.calib, res_reg.latched,
        res_reg.running, res_reg.gain, res_reg.trip_code, res_reg.outcome,
        res_reg.accepted};

    `include "tx_alc_guard_assert.svh"
    `TAG_ASSERT_IMP(a_trip_ends, aclk, aresetn, ov_reg && res_reg.close_s,
        !res_reg.running && res_reg.latched)
    `TAG_ASSERT_IMP(a_cal_needs_run, aclk, aresetn, ov_reg && res_reg.calib, res_reg.running)
    `TAG_ASSERT_NEXT(a_take_shows, aclk, aresetn, take, m_tvalid)
endmodule

// ===== sv/tx_alc_guard.sv =====
`timescale 1ns / 1ps
// channel   direction  tdata fields (low bit up)
// s_        in         action, now_ms, session_id, calibrate, hdrm_fault,
//                      cancelled, meter_ok, alc, compression, rf_power
// m_        out        accepted, outcome, trip_code, drive_gain, running,
//                      latched_trip, in_calibration, close_session
// cfg       in         cfg_we, cfg_addr, cfg_wdata
// one request per cycle sustained while m_ takes results; the result registers at the
// edge its request leaves the two entry input queue
// reset is synchronous and clears queue, flags and registers to defaults
// a stalled m_ side holds one result; the queue keeps s_ taking two more
module tx_alc_guard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // action, now_ms, session_id, calibrate, hdrm_fault,
                                  // cancelled, meter_ok, alc, compression, rf_power
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // accepted, outcome, trip_code, drive_gain, running,
                                  // latched_trip, in_calibration, close_session
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    logic            q_valid, q_ready;
    tag_pkg::event_t q_event;

    tag_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_event(q_event)
    );

    tag_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .q_valid(q_valid), .q_ready(q_ready),
        .q_event(q_event), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

// ===== tb/tb_tx_alc_guard.sv =====
`timescale 1ns / 1ps
module tb_tx_alc_guard;
    import tag_pkg::*;

    localparam logic [2:0] ACT_UNUSED = 3'd5;
    localparam int ST_STABLE = 0, ST_FIRST = 1, ST_LAST = 2, ST_HSINCE = 3, ST_LRED = 4,
                   ST_LHIGH = 5;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] now;
        logic [15:0] sid;
        logic        cal;
        logic        fault;
        logic        cancel;
        logic        mok;
        logic [9:0]  alc;
        logic [9:0]  comp;
        logic [9:0]  rf;
    } req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    tx_alc_guard u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // guard state mirror
    logic [15:0] c_min, c_cal, c_max, c_to;
    logic [9:0]  c_red, c_stop;
    logic        g_run, g_latch, g_cal, pulse;
    logic [15:0] g_gain;
    logic [31:0] t_start, t_adj, t_meter;
    logic [31:0] st_v [6];
    logic        st_ok [6];
    logic [3:0]  hi_cnt, tcode;

    req_t    pending_reqs [$];
    result_t guard_results [$];
    req_t    cur;
    int      s_idle, r_idle, n_sent, n_checked, n_trip, n_red, n_calok, errors, cycles;
    logic [31:0] t_now;

    function automatic logic older(input logic [31:0] now, input logic [31:0] t,
                                   input logic [31:0] k);
        return now >= t && now - t >= k;
    endfunction

    function automatic logic [1:0] trip(input logic [3:0] code);
        if (!g_run) return OUT_NONE;
        g_run = 1'b0;
        g_cal = 1'b0;
        g_latch = 1'b1;
        pulse = 1'b1;
        tcode = code;
        return OUT_TRIP;
    endfunction

    function automatic logic [1:0] tick_check(input logic [31:0] now, input logic f,
                                              input logic c);
        logic [31:0] ref_t;
        if (!g_run) return OUT_NONE;
        if (f) return trip(TRIP_FAULT);
        if (c) return trip(TRIP_CANCEL);
        if (now < t_meter || now - t_meter >= {16'd0, c_to}) return trip(TRIP_METER_TO);
        if (hi_cnt >= 3 && st_ok[ST_HSINCE] && older(now, st_v[ST_HSINCE], 1500))
            return trip(TRIP_ALC_PERS);
        if (g_cal && older(now, t_start, 15000)) return trip(TRIP_CAL_TO);
        ref_t = st_ok[ST_LAST] ? st_v[ST_LAST] : t_start;
        if (older(now, ref_t, 1500)) return trip(TRIP_NO_AUDIO);
        return OUT_NONE;
    endfunction

    function automatic void clear_high();
        st_ok[ST_HSINCE] = 1'b0;
        st_ok[ST_LHIGH] = 1'b0;
        hi_cnt = 4'd0;
    endfunction

    function automatic logic [1:0] meter_check(input req_t q);
        logic        first_ok;
        logic [1:0]  r;
        logic [63:0] prod;
        first_ok = st_ok[ST_FIRST];
        if (!g_run) return OUT_NONE;
        if (!q.mok) return trip(TRIP_BAD_METER);
        r = tick_check(q.now, q.fault, q.cancel);
        if (r != OUT_NONE) return r;
        t_meter = q.now;
        if (g_cal && q.rf > 0) return trip(TRIP_RF);
        if (q.comp > 0) return trip(TRIP_COMP);
        if (q.alc >= c_stop) return trip(TRIP_ALC_EXC);
        if (g_cal && (!first_ok || !older(q.now, st_v[ST_FIRST], 600) ||
                      !older(q.now, t_adj, 600))) begin
            clear_high();
            st_ok[ST_STABLE] = 1'b0;
            return OUT_NONE;
        end
        if (q.alc < c_red) begin
            clear_high();
            if (g_cal) begin
                if (!first_ok || !older(q.now, st_v[ST_FIRST], 600) || !st_ok[ST_LAST] ||
                    (q.now > st_v[ST_LAST] && q.now - st_v[ST_LAST] > 500) ||
                    !older(q.now, t_adj, 600)) begin
                    st_ok[ST_STABLE] = 1'b0;
                    return OUT_NONE;
                end
                if (q.alc >= 3) begin
                    if (!st_ok[ST_STABLE]) begin
                        st_ok[ST_STABLE] = 1'b1;
                        st_v[ST_STABLE] = q.now;
                    end
                    if (older(q.now, st_v[ST_STABLE], 1200)) return OUT_CALIB;
                end else begin
                    st_ok[ST_STABLE] = 1'b0;
                    if (older(q.now, t_adj, 600)) begin
                        if (g_gain >= c_max) return trip(TRIP_CAL_GAIN);
                        prod = (64'(g_gain) * 64'd92682) >> 16;
                        g_gain = (prod < 64'(c_max)) ? prod[15:0] : c_max;
                        t_adj = q.now;
                    end
                end
            end
            return OUT_NONE;
        end
        st_ok[ST_STABLE] = 1'b0;
        if (!st_ok[ST_HSINCE]) begin
            st_ok[ST_HSINCE] = 1'b1;
            st_v[ST_HSINCE] = q.now;
        end
        if (!st_ok[ST_LHIGH] || older(q.now, st_v[ST_LHIGH], 200)) begin
            if (hi_cnt < 15) hi_cnt++;
            st_ok[ST_LHIGH] = 1'b1;
            st_v[ST_LHIGH] = q.now;
        end
        if (st_ok[ST_LRED] && !older(q.now, st_v[ST_LRED], 400)) return OUT_NONE;
        if (g_gain <= c_min) begin
            if (hi_cnt >= 3 && older(q.now, st_v[ST_HSINCE], 600)) return trip(TRIP_ALC_MIN);
            return OUT_NONE;
        end
        prod = (64'(g_gain) * 64'd46341) >> 16;
        g_gain = (prod > 64'(c_min)) ? prod[15:0] : c_min;
        t_adj = q.now;
        st_ok[ST_LRED] = 1'b1;
        st_v[ST_LRED] = q.now;
        if (g_cal) clear_high();
        return OUT_RED;
    endfunction

    function automatic result_t guard_step(input req_t q);
        result_t     r;
        logic [15:0] g;
        r = '0;
        pulse = 1'b0;
        tcode = TRIP_NONE;
        case (q.action)
            ACT_BEGIN: begin
                if (!g_run && !g_latch && q.sid != 0) begin
                    r.accepted = 1'b1;
                    g_run = 1'b1;
                    g_cal = q.cal;
                    t_start = q.now;
                    t_adj = q.now;
                    t_meter = q.now;
                    for (int i = 0; i < 6; i++) begin
                        st_ok[i] = 1'b0;
                        st_v[i] = '0;
                    end
                    hi_cnt = 4'd0;
                    if (q.cal) begin
                        g_gain = c_cal;
                    end else begin
                        g = (g_gain < c_max) ? g_gain : c_max;
                        g_gain = (g > c_min) ? g : c_min;
                    end
                end
            end
            ACT_ACK: if (!g_run) g_latch = 1'b0;
            ACT_AUDIO: begin
                if (g_run) begin
                    if (!st_ok[ST_FIRST]) begin
                        st_ok[ST_FIRST] = 1'b1;
                        st_v[ST_FIRST] = q.now;
                        t_adj = q.now;
                    end
                    st_ok[ST_LAST] = 1'b1;
                    st_v[ST_LAST] = q.now;
                end
            end
            ACT_TICK: r.outcome = tick_check(q.now, q.fault, q.cancel);
            ACT_METER: r.outcome = meter_check(q);
            default: ;
        endcase
        r.trip_code = tcode;
        r.gain = g_gain;
        r.running = g_run;
        r.latched = g_latch;
        r.calib = g_cal;
        r.close_s = pulse;
        return r;
    endfunction

    function automatic logic [95:0] pack_req(input req_t q);
        return {11'd0, q.rf, q.comp, q.alc, q.mok, q.cancel, q.fault, q.cal, q.sid, q.now,
                q.action};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                guard_results.push_back(guard_step(cur));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= s_idle) begin
                    cur = pending_reqs.pop_front();
                    s_tdata <= pack_req(cur);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t e;
        cycles++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= r_idle);
            if (m_tvalid && m_tready) begin
                if (guard_results.size() == 0) begin
                    $error("result with no request pending: %h", m_tdata);
                    errors++;
                end else begin
                    e = guard_results.pop_front();
                    n_checked++;
                    if (e.outcome == OUT_TRIP) n_trip++;
                    if (e.outcome == OUT_RED) n_red++;
                    if (e.outcome == OUT_CALIB) n_calok++;
                    if (m_tdata[0] !== e.accepted) begin
                        $error("accepted exp %0d got %0d", e.accepted, m_tdata[0]); errors++;
                    end
                    if (m_tdata[2:1] !== e.outcome) begin
                        $error("outcome exp %0d got %0d", e.outcome, m_tdata[2:1]); errors++;
                    end
                    if (m_tdata[6:3] !== e.trip_code) begin
                        $error("trip_code exp %0d got %0d", e.trip_code, m_tdata[6:3]); errors++;
                    end
                    if (m_tdata[22:7] !== e.gain) begin
                        $error("drive_gain exp %0d got %0d", e.gain, m_tdata[22:7]); errors++;
                    end
                    if (m_tdata[23] !== e.running) begin
                        $error("running exp %0d got %0d", e.running, m_tdata[23]); errors++;
                    end
                    if (m_tdata[24] !== e.latched) begin
                        $error("latched_trip exp %0d got %0d", e.latched, m_tdata[24]); errors++;
                    end
                    if (m_tdata[25] !== e.calib) begin
                        $error("in_calibration exp %0d got %0d", e.calib, m_tdata[25]); errors++;
                    end
                    if (m_tdata[26] !== e.close_s) begin
                        $error("close_session exp %0d got %0d", e.close_s, m_tdata[26]); errors++;
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic req_t mk(input logic [2:0] act);
        req_t q;
        q.action = act;
        q.now = t_now;
        q.sid = 16'($urandom);
        q.cal = 1'($urandom_range(1));
        q.fault = ($urandom_range(59) == 0);
        q.cancel = ($urandom_range(59) == 0);
        q.mok = ($urandom_range(39) != 0);
        q.alc = ($urandom_range(9) == 0) ? 10'($urandom_range(999)) : 10'($urandom_range(14));
        q.comp = ($urandom_range(39) == 0) ? 10'($urandom_range(999)) : 10'd0;
        q.rf = ($urandom_range(19) == 0) ? 10'($urandom_range(999)) : 10'd0;
        return q;
    endfunction

    task automatic add(input req_t q);
        pending_reqs.push_back(q);
    endtask

    task automatic session();
        req_t q;
        int   n, r;
        t_now += $urandom_range(3000);
        q = mk(ACT_BEGIN);
        if ($urandom_range(19) == 0) q.sid = 0;
        else if (q.sid == 0) q.sid = 16'd1;
        add(q);
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(99) < 8) t_now += $urandom_range(2000);
            else if ($urandom_range(99) == 0) t_now -= $urandom_range(1000);
            else t_now += $urandom_range(250);
            if (r < 30) q = mk(ACT_AUDIO);
            else if (r < 40) q = mk(ACT_TICK);
            else if (r < 90) q = mk(ACT_METER);
            else if (r < 93) q = mk(ACT_ACK);
            else if (r < 96) q = mk(ACT_UNUSED + 3'($urandom_range(2)));
            else q = mk(ACT_BEGIN);
            add(q);
        end
        add(mk(ACT_ACK));
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_GAIN: c_min = val;
            REG_CAL_GAIN: c_cal = val;
            REG_MAX_GAIN: c_max = val;
            REG_REDUCE:   c_red = val[9:0];
            REG_STOP:     c_stop = val[9:0];
            default:      c_to = val;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || guard_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic directed();
        req_t q;
        t_now = 32'd0;
        q = mk(ACT_BEGIN); q.sid = 0; add(q);
        q = mk(ACT_UNUSED); add(q);
        q = mk(3'd7); add(q);
        q = mk(ACT_BEGIN); q.sid = 16'hFFFF; q.cal = 0; add(q);
        q = mk(ACT_BEGIN); add(q);
        q = mk(ACT_ACK); add(q);
        t_now = 100; q = mk(ACT_AUDIO); add(q);
        t_now = 200; q = mk(ACT_METER); q.mok = 1; q.fault = 0; q.cancel = 0; q.alc = 7;
        q.comp = 0; q.rf = 10'd999; add(q);
        t_now = 300; q = mk(ACT_METER); q.mok = 0; add(q);
        q = mk(ACT_BEGIN); q.sid = 1; add(q);
        q = mk(ACT_AUDIO); add(q);
        q = mk(ACT_ACK); add(q);
        q = mk(ACT_BEGIN); q.sid = 2; q.cal = 1; add(q);
        q = mk(ACT_TICK); q.fault = 1; add(q);
        q = mk(ACT_ACK); add(q);
        q = mk(ACT_BEGIN); q.sid = 3; add(q);
        q = mk(ACT_TICK); q.fault = 0; q.cancel = 1; add(q);
        q = mk(ACT_ACK); add(q);
        q = mk(ACT_BEGIN); q.sid = 4; add(q);
        t_now = 32'hFFFF_FFFF;
        q = mk(ACT_METER); q.mok = 1; q.fault = 0; q.cancel = 0; q.alc = 10'd999;
        q.comp = 10'd999; add(q);
        q = mk(ACT_ACK); add(q);
        q = mk(ACT_BEGIN); q.sid = 5; add(q);
        t_now = 32'd10;
        q = mk(ACT_TICK); q.fault = 0; q.cancel = 0; add(q);
        q = mk(ACT_ACK); add(q);
    endtask

    task automatic phase(input int sid_pct, input int rid_pct, input logic [15:0] mn,
                         input logic [15:0] cg, input logic [15:0] mx, input logic [15:0] rd,
                         input logic [15:0] sp, input logic [15:0] to);
        int target;
        cfg_write(REG_MIN_GAIN, mn);
        cfg_write(REG_CAL_GAIN, cg);
        cfg_write(REG_MAX_GAIN, mx);
        cfg_write(REG_REDUCE, rd);
        cfg_write(REG_STOP, sp);
        cfg_write(REG_METER_TO, to);
        s_idle = sid_pct;
        r_idle = rid_pct;
        t_now = $urandom;
        target = n_sent + 215;
        while (n_sent + pending_reqs.size() < target) session();
        drain();
    endtask

    initial begin
        c_min = 16; c_cal = 1024; c_max = 32768; c_red = 5; c_stop = 10; c_to = 1000;
        g_run = 0; g_latch = 0; g_cal = 0; g_gain = 0; t_start = 0; t_adj = 0; t_meter = 0;
        hi_cnt = 4'd0; pulse = 0; tcode = TRIP_NONE;
        for (int i = 0; i < 6; i++) begin
            st_ok[i] = 0;
            st_v[i] = 0;
        end
        s_idle = 10; r_idle = 81;
        n_sent = 0; n_checked = 0; n_trip = 0; n_red = 0; n_calok = 0; errors = 0; cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        directed();
        drain();
        phase(10, 81, 16, 1024, 32768, 5, 10, 1000);
        phase(10, 81, 0, 32768, 32768, 0, 999, 65535);
        phase(81, 10, 32768, 0, 0, 999, 0, 1);
        phase(81, 10, 100, 200, 20000, 3, 8, 500);
        phase(0, 0, 16'($urandom_range(32768)), 16'($urandom_range(32768)),
              16'($urandom_range(32768)), 16'($urandom_range(999)),
              16'($urandom_range(999)), 16'($urandom_range(1, 65535)));
        phase(0, 0, 16, 1024, 32768, 5, 10, 1000);
        $display("%0d requests checked over six register settings and three idle patterns",
                 n_checked);
        $display("%0d trips, %0d gain reductions, %0d calibrations completed",
                 n_trip, n_red, n_calok);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
